// ----- rtl/core/obd_pkg.sv -----
package obd_pkg;

	// Levels kept per side, and the cap on results of one update.
	localparam int unsigned DEPTH       = 8;
	localparam int unsigned MAX_RESULTS = 32;

	localparam int unsigned IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW  = $clog2(DEPTH + 1);
	localparam int unsigned RESW  = $clog2(MAX_RESULTS + 1);
	// Address: bank, side, index within the side.
	localparam int unsigned ADDRW = IDXW + 2;
	localparam int unsigned MEMD  = 1 << ADDRW;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef logic [CNTW-1:0]  cnt_t;
	typedef logic [RESW-1:0]  res_cnt_t;
	typedef logic [ADDRW-1:0] addr_t;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] qty;
	} level_t;

	typedef struct packed {
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
	} change_t;

	// True when price a ranks ahead of price b on the given side.
	function automatic logic ahead(input logic side, input logic [31:0] a,
			input logic [31:0] b);
		return (side == SIDE_ASK) ? (a < b) : (a > b);
	endfunction

	function automatic addr_t mem_addr(input logic bank, input logic side,
			input cnt_t idx);
		return {bank, side, idx[IDXW-1:0]};
	endfunction

endpackage

// ----- rtl/core/obd_ifs.sv -----
interface obd_level_if;
	logic        valid;
	logic        ready;
	logic        level_side;
	logic [31:0] level_price;
	logic [31:0] level_qty;
	logic        has_level;
	logic        side_done;
	logic        full_snapshot;

	modport source (output valid, level_side, level_price, level_qty, has_level,
		side_done, full_snapshot, input ready);
	modport sink (input valid, level_side, level_price, level_qty, has_level,
		side_done, full_snapshot, output ready);
endinterface

interface obd_change_if;
	logic        valid;
	logic        ready;
	logic        change_side;
	logic [31:0] change_price;
	logic [31:0] change_qty;
	logic        last_change;

	modport source (output valid, change_side, change_price, change_qty,
		last_change, input ready);
	modport sink (input valid, change_side, change_price, change_qty,
		last_change, output ready);
endinterface

// ----- rtl/core/order_book_top_level_diff.sv -----
// Level items are taken only while idle; the item closing the ask side starts the diff.
// The diff walks bids then asks; each merge step is a memory read, then a compare that
// stalls while the result sink holds back, with at most nb plus the current level count
// steps per side. Both level sets share one two-bank level memory.
// Reset clears the level counts, the bank select and the result valid flags; the
// memory itself is not cleared, since a value read from a never-written entry is not used.
module order_book_top_level_diff (
	input logic clk,
	input logic arst_n,
	obd_level_if.sink lvl,
	obd_change_if.source chg
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_FLUSH
	} state_t;

	state_t state_q;

	// Bank holding the published levels; the other bank gathers the current ones.
	logic pub_bank_q;
	obd_pkg::cnt_t pub_cnt_q [2];
	obd_pkg::cnt_t cur_cnt_q [2];

	logic          side_q;
	logic          snap_q;
	obd_pkg::cnt_t i_q;
	obd_pkg::cnt_t j_q;
	obd_pkg::cnt_t nb_q;
	obd_pkg::res_cnt_t res_cnt_q;

	obd_pkg::level_t mem_q [obd_pkg::MEMD];
	obd_pkg::level_t rd_old_q;
	obd_pkg::level_t rd_cur_q;

	logic             pend_v_q;
	obd_pkg::change_t pend_q;
	logic             out_v_q;
	obd_pkg::change_t out_q;
	logic             out_last_q;

	logic          accept;
	logic          closing;
	logic          wr_en;
	obd_pkg::addr_t wr_addr;
	logic          io;
	logic          jo;
	logic          more;
	logic          rd_en;
	logic          take_old;
	logic          take_cur;
	logic          emit_want;
	logic          emit_ok;
	logic [31:0]   new_price;
	logic [31:0]   new_qty;
	logic          out_free;
	logic          stall;
	logic          load_pend;
	logic          move_out;

	assign lvl.ready = (state_q == S_IDLE);
	assign accept    = lvl.valid && lvl.ready;
	assign closing   = lvl.side_done && (lvl.level_side == obd_pkg::SIDE_ASK);
	assign wr_en     = accept && lvl.has_level &&
		(cur_cnt_q[lvl.level_side] < obd_pkg::CNTW'(obd_pkg::DEPTH));
	assign wr_addr   = obd_pkg::mem_addr(!pub_bank_q, lvl.level_side,
		cur_cnt_q[lvl.level_side]);

	assign io    = i_q < nb_q;
	assign jo    = j_q < cur_cnt_q[side_q];
	assign more  = io || jo;
	assign rd_en = (state_q == S_RD) && more;

	// One merge step on the registered pair of levels.
	always_comb begin
		take_old  = !jo || (io && obd_pkg::ahead(side_q, rd_old_q.price, rd_cur_q.price));
		take_cur  = !take_old &&
			(!io || obd_pkg::ahead(side_q, rd_cur_q.price, rd_old_q.price));
		new_price = take_old ? rd_old_q.price : rd_cur_q.price;
		new_qty   = take_old ? 32'd0 : rd_cur_q.qty;
		emit_want = take_old || take_cur || (rd_old_q.qty != rd_cur_q.qty);
	end

	assign emit_ok   = emit_want && (res_cnt_q < obd_pkg::RESW'(obd_pkg::MAX_RESULTS));
	assign out_free  = !out_v_q || chg.ready;
	assign stall     = emit_ok && pend_v_q && !out_free;
	assign load_pend = (state_q == S_CMP) && emit_ok && !stall;
	assign move_out  = pend_v_q && ((load_pend) || ((state_q == S_FLUSH) && out_free));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= '{price: lvl.level_price, qty: lvl.level_qty};
		end
		if (rd_en) begin
			rd_old_q <= mem_q[obd_pkg::mem_addr(pub_bank_q, side_q, i_q)];
			rd_cur_q <= mem_q[obd_pkg::mem_addr(!pub_bank_q, side_q, j_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend) begin
			pend_q <= '{side: side_q, price: new_price, qty: new_qty};
		end
		if (move_out) begin
			out_q      <= pend_q;
			out_last_q <= (state_q == S_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pub_bank_q <= 1'b0;
			pub_cnt_q  <= '{default: '0};
			cur_cnt_q  <= '{default: '0};
			side_q     <= obd_pkg::SIDE_BID;
			snap_q     <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			nb_q       <= '0;
			res_cnt_q  <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (move_out) begin
				out_v_q <= 1'b1;
			end else if (chg.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (wr_en) begin
						cur_cnt_q[lvl.level_side] <= cur_cnt_q[lvl.level_side] + 1'b1;
					end
					if (accept && closing) begin
						side_q    <= obd_pkg::SIDE_BID;
						snap_q    <= lvl.full_snapshot;
						nb_q      <= lvl.full_snapshot ? '0 : pub_cnt_q[0];
						i_q       <= '0;
						j_q       <= '0;
						res_cnt_q <= '0;
						state_q   <= S_RD;
					end
				end
				S_RD: begin
					if (more) begin
						state_q <= S_CMP;
					end else if (side_q == obd_pkg::SIDE_BID) begin
						side_q <= obd_pkg::SIDE_ASK;
						nb_q   <= snap_q ? '0 : pub_cnt_q[1];
						i_q    <= '0;
						j_q    <= '0;
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_CMP: begin
					if (!stall) begin
						if (take_old) begin
							i_q <= i_q + 1'b1;
						end else if (take_cur) begin
							j_q <= j_q + 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= j_q + 1'b1;
						end
						if (emit_ok) begin
							pend_v_q  <= 1'b1;
							res_cnt_q <= res_cnt_q + 1'b1;
						end
						state_q <= S_RD;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q || out_free) begin
						// The held result is the last one; the gathered bank becomes published.
						pend_v_q   <= 1'b0;
						pub_bank_q <= !pub_bank_q;
						pub_cnt_q  <= cur_cnt_q;
						cur_cnt_q  <= '{default: '0};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign chg.valid        = out_v_q;
	assign chg.change_side  = out_q.side;
	assign chg.change_price = out_q.price;
	assign chg.change_qty   = out_q.qty;
	assign chg.last_change  = out_last_q;

endmodule

// ----- rtl/core/obd_checker.sv -----
module obd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        lvl_valid,
	input logic        lvl_ready,
	input logic        lvl_side,
	input logic        lvl_done,
	input logic        chg_valid,
	input logic        chg_ready,
	input logic [31:0] chg_price,
	input logic [31:0] chg_qty,
	input logic        chg_last
);

	// A result that is not taken stays offered unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chg_valid && !chg_ready |=> chg_valid && $stable(chg_price) &&
		$stable(chg_qty) && $stable(chg_last))
		else $error("stalled result changed");

	// The closing ask item starts the diff, so no level is taken in the next cycle.
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_valid && lvl_ready && lvl_side && lvl_done |=> !lvl_ready)
		else $error("input taken while the diff starts");

	// Any other level item only loads the memory and leaves the input open.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_valid && lvl_ready && !(lvl_side && lvl_done) |=> lvl_ready)
		else $error("input closed after a plain level item");

	// Results are produced only by the diff, so none appears while the input is open.
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_ready && !chg_valid |=> !chg_valid)
		else $error("result offered while no diff was running");

endmodule

bind order_book_top_level_diff obd_checker u_obd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.lvl_valid (lvl.valid),
	.lvl_ready (lvl.ready),
	.lvl_side  (lvl.level_side),
	.lvl_done  (lvl.side_done),
	.chg_valid (chg.valid),
	.chg_ready (chg.ready),
	.chg_price (chg.change_price),
	.chg_qty   (chg.change_qty),
	.chg_last  (chg.last_change)
);
